>>> design/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
// No dependencies; used by every module of the block.
package ptd_pkg;

   // Table geometry and result limits
   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int CNT_W         = 7;
   localparam int TIME_W        = 32;
   localparam int ID_W          = 8;
   localparam int OP_W          = 3;

   localparam logic [ID_W-1:0]   NO_SLOT        = 8'hFF;
   localparam logic [TIME_W-1:0] DEFAULT_PERIOD = 32'd100;

   // Opcodes of a request word
   localparam logic [OP_W-1:0] OP_RUN       = 3'd0;
   localparam logic [OP_W-1:0] OP_REGISTER  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

   // Write request into the slot store
   typedef struct packed {
      logic              period_en;
      logic              last_en;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] last_time;
   } slot_wr_type;

endpackage

>>> design/ptd_due_cmp.sv
// Shared elapsed-time compare unit: wrapping (now - last) against the period.
// Depends on ptd_pkg.
module ptd_due_cmp (
   input  logic [ptd_pkg::TIME_W-1:0] now_ms,
   input  logic [ptd_pkg::TIME_W-1:0] last_time,
   input  logic [ptd_pkg::TIME_W-1:0] period,
   output logic                       due
);

   logic [ptd_pkg::TIME_W-1:0] elapsed;

   // modulo 2^32 subtraction, then one unsigned compare
   assign elapsed = now_ms - last_time;
   assign due     = (elapsed >= period);

endmodule

>>> design/ptd_slot_mem.sv
// Slot store: period and last-run memories, one write and one registered read.
// Slot 0 reads back its reset value until first written. Depends on ptd_pkg.
module ptd_slot_mem #(
   parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF,
   parameter int IDXW      = $clog2(NUM_SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [IDXW-1:0]            rd_addr,
   input  logic [IDXW-1:0]            wr_addr,
   input  ptd_pkg::slot_wr_type       wr,
   output logic [ptd_pkg::TIME_W-1:0] rd_period,
   output logic [ptd_pkg::TIME_W-1:0] rd_last
);

   logic [ptd_pkg::TIME_W-1:0] period_mem [NUM_SLOTS];
   logic [ptd_pkg::TIME_W-1:0] last_mem   [NUM_SLOTS];

   logic [ptd_pkg::TIME_W-1:0] rd_period_ff;
   logic [ptd_pkg::TIME_W-1:0] rd_last_ff;
   logic                       p0_written_ff, p0_written_in;
   logic                       l0_written_ff, l0_written_in;
   logic                       p_rst_ff, p_rst_in;
   logic                       l_rst_ff, l_rst_in;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr.period_en) begin
         period_mem[wr_addr] <= wr.period;
      end
      if (wr.last_en) begin
         last_mem[wr_addr] <= wr.last_time;
      end
      rd_period_ff <= period_mem[rd_addr];
      rd_last_ff   <= last_mem[rd_addr];
   end

   // slot 0 holds reset values until its first write
   always_comb begin
      p0_written_in = p0_written_ff | (wr.period_en & (wr_addr == '0));
      l0_written_in = l0_written_ff | (wr.last_en & (wr_addr == '0));
      p_rst_in      = (rd_addr == '0) & ~p0_written_ff;
      l_rst_in      = (rd_addr == '0) & ~l0_written_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_written_ff <= 1'b0;
         l0_written_ff <= 1'b0;
         p_rst_ff      <= 1'b0;
         l_rst_ff      <= 1'b0;
      end else begin
         p0_written_ff <= p0_written_in;
         l0_written_ff <= l0_written_in;
         p_rst_ff      <= p_rst_in;
         l_rst_ff      <= l_rst_in;
      end
   end

   assign rd_period = p_rst_ff ? ptd_pkg::DEFAULT_PERIOD : rd_period_ff;
   assign rd_last   = l_rst_ff ? '0 : rd_last_ff;

endmodule

>>> design/periodic_task_dispatcher_core.sv
// Periodic task dispatcher: slot sequencer, valid bits, output register.
// Run: an accept step, a scan over the slots, then a finish step,
// one slot per cycle through the shared compare unit and the slot store's read port.
// Register scans from slot 0 for the first free slot; remove, overwrite, query and unknown need no scan.
// One request word at a time; output stalls hold the scan. Synchronous reset:
// slot 0 valid with 100 ms period and last run 0, other slots free, count one.
module periodic_task_dispatcher_core #(
   parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ptd_pkg::OP_W-1:0]   req_opcode,
   input  logic [ptd_pkg::TIME_W-1:0] req_now_ms,
   input  logic [ptd_pkg::TIME_W-1:0] req_interval_ms,
   input  logic [ptd_pkg::ID_W-1:0]   req_task_id,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ptd_pkg::OP_W-1:0]   rsp_result_kind,
   output logic [ptd_pkg::ID_W-1:0]   rsp_slot_id,
   output logic                       rsp_ok,
   output logic [ptd_pkg::TIME_W-1:0] rsp_slot_interval,
   output logic [ptd_pkg::TIME_W-1:0] rsp_slot_last_time,
   output logic [ptd_pkg::CNT_W-1:0]  rsp_active_count,
   output logic                       rsp_last
);

   localparam int IDXW = $clog2(NUM_SLOTS);
   localparam int RCW  = ptd_pkg::RES_CNT_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   // sequencer state
   logic [1:0]                 state_ff, state_in;
   logic [ptd_pkg::OP_W-1:0]   op_ff, op_in;
   logic [ptd_pkg::TIME_W-1:0] now_ff, now_in;
   logic [ptd_pkg::TIME_W-1:0] ivl_ff, ivl_in;
   logic                       id_ok_ff, id_ok_in;
   logic [IDXW-1:0]            addr_ff, addr_in;
   logic [RCW-1:0]             n_ff, n_in;
   logic                       pend_ff, pend_in;
   logic [IDXW-1:0]            pend_id_ff, pend_id_in;
   logic [NUM_SLOTS-1:0]       valid_ff, valid_in;
   logic [ptd_pkg::CNT_W-1:0]  count_ff, count_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ptd_pkg::OP_W-1:0]   rsp_kind_ff;
   logic [ptd_pkg::ID_W-1:0]   rsp_slot_ff;
   logic                       rsp_ok_ff;
   logic [ptd_pkg::TIME_W-1:0] rsp_ivl_ff;
   logic [ptd_pkg::TIME_W-1:0] rsp_lt_ff;
   logic [ptd_pkg::CNT_W-1:0]  rsp_cnt_ff;
   logic                       rsp_last_ff;

   // word being emitted this cycle
   logic                       emit;
   logic [ptd_pkg::ID_W-1:0]   e_slot;
   logic                       e_ok;
   logic [ptd_pkg::TIME_W-1:0] e_ivl;
   logic [ptd_pkg::TIME_W-1:0] e_lt;
   logic                       e_last;

   logic                       out_free;
   logic                       slot_valid;
   logic                       last_slot;
   logic                       due;
   logic [RCW-1:0]             n_plus;
   logic [ptd_pkg::TIME_W-1:0] rd_period;
   logic [ptd_pkg::TIME_W-1:0] rd_last;
   ptd_pkg::slot_wr_type       wr;

   ptd_slot_mem #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDXW      (IDXW)
   ) u_slot_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (addr_in),
      .wr_addr   (addr_ff),
      .wr        (wr),
      .rd_period (rd_period),
      .rd_last   (rd_last)
   );

   ptd_due_cmp u_due_cmp (
      .now_ms    (now_ff),
      .last_time (rd_last),
      .period    (rd_period),
      .due       (due)
   );

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign slot_valid = valid_ff[addr_ff];
   assign last_slot  = (addr_ff == IDXW'(NUM_SLOTS - 1));
   assign n_plus     = n_ff + 1'b1;
   assign req_ready  = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      ivl_in     = ivl_ff;
      id_ok_in   = id_ok_ff;
      addr_in    = addr_ff;
      n_in       = n_ff;
      pend_in    = pend_ff;
      pend_id_in = pend_id_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      emit       = 1'b0;
      e_slot     = ptd_pkg::NO_SLOT;
      e_ok       = 1'b0;
      e_ivl      = '0;
      e_lt       = '0;
      e_last     = 1'b1;
      wr         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               now_in   = req_now_ms;
               ivl_in   = req_interval_ms;
               id_ok_in = (req_task_id < ptd_pkg::ID_W'(NUM_SLOTS));
               if (req_opcode inside {ptd_pkg::OP_REMOVE, ptd_pkg::OP_QUERY}) begin
                  addr_in = req_task_id[IDXW-1:0];
               end else begin
                  addr_in = '0;
               end
               n_in     = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            case (op_ff)
               ptd_pkg::OP_RUN: begin
                  if (slot_valid && due) begin
                     // a new due slot releases the previous one as a non-final word
                     if (!pend_ff || out_free) begin
                        emit          = pend_ff;
                        e_slot        = ptd_pkg::ID_W'(pend_id_ff);
                        e_ok          = 1'b1;
                        e_last        = 1'b0;
                        wr.last_en    = 1'b1;
                        wr.last_time  = now_ff;
                        pend_in       = 1'b1;
                        pend_id_in    = addr_ff;
                        n_in          = n_plus;
                        if (last_slot || n_plus == RCW'(ptd_pkg::MAX_RESULTS)) begin
                           state_in = S_FLUSH;
                        end else begin
                           addr_in = addr_ff + 1'b1;
                        end
                     end
                  end else if (last_slot) begin
                     state_in = S_FLUSH;
                  end else begin
                     addr_in = addr_ff + 1'b1;
                  end
               end

               ptd_pkg::OP_REGISTER: begin
                  if (out_free) begin
                     if (!slot_valid) begin
                        valid_in[addr_ff] = 1'b1;
                        count_in          = count_ff + 1'b1;
                        wr.period_en      = 1'b1;
                        wr.period         = ivl_ff;
                        wr.last_en        = 1'b1;
                        wr.last_time      = now_ff;
                        emit              = 1'b1;
                        e_slot            = ptd_pkg::ID_W'(addr_ff);
                        e_ok              = 1'b1;
                        state_in          = S_IDLE;
                     end else if (last_slot) begin
                        emit     = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        addr_in = addr_ff + 1'b1;
                     end
                  end
               end

               ptd_pkg::OP_REMOVE: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (id_ok_ff && slot_valid) begin
                        valid_in[addr_ff] = 1'b0;
                        count_in          = count_ff - 1'b1;
                        e_slot            = ptd_pkg::ID_W'(addr_ff);
                        e_ok              = 1'b1;
                     end
                  end
               end

               ptd_pkg::OP_OVERWRITE: begin
                  // address is slot 0 here; the valid bit is left alone
                  if (out_free) begin
                     wr.period_en = 1'b1;
                     wr.period    = ivl_ff;
                     wr.last_en   = 1'b1;
                     wr.last_time = now_ff;
                     emit         = 1'b1;
                     e_slot       = '0;
                     e_ok         = valid_ff[0];
                     state_in     = S_IDLE;
                  end
               end

               ptd_pkg::OP_QUERY: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (id_ok_ff && slot_valid) begin
                        e_slot = ptd_pkg::ID_W'(addr_ff);
                        e_ok   = 1'b1;
                        e_ivl  = rd_period;
                        e_lt   = rd_last;
                     end
                  end
               end

               default: begin
                  // unknown opcode: echo it with no slot
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         S_FLUSH: begin
            // final word of a run: held due slot, or the nothing-due word
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (pend_ff) begin
                  e_slot = ptd_pkg::ID_W'(pend_id_ff);
                  e_ok   = 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
         valid_ff     <= NUM_SLOTS'(1);
         count_ff     <= ptd_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      now_ff     <= now_in;
      ivl_ff     <= ivl_in;
      id_ok_ff   <= id_ok_in;
      addr_ff    <= addr_in;
      pend_id_ff <= pend_id_in;
      if (emit) begin
         rsp_kind_ff <= op_ff;
         rsp_slot_ff <= e_slot;
         rsp_ok_ff   <= e_ok;
         rsp_ivl_ff  <= e_ivl;
         rsp_lt_ff   <= e_lt;
         rsp_cnt_ff  <= count_in;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_slot_id        = rsp_slot_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_slot_interval  = rsp_ivl_ff;
   assign rsp_slot_last_time = rsp_lt_ff;
   assign rsp_active_count   = rsp_cnt_ff;
   assign rsp_last           = rsp_last_ff;

   // checks
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == ptd_pkg::CNT_W'($countones(valid_ff)))
      else $error("active count out of step with slot valid bits");

   a_ok_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff && (rsp_kind_ff != ptd_pkg::OP_OVERWRITE)
      |-> rsp_slot_ff < ptd_pkg::ID_W'(NUM_SLOTS))
      else $error("successful word carries a slot beyond the table");

   a_flush_only_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> op_ff == ptd_pkg::OP_RUN)
      else $error("finish state entered by a non-run word");

   a_run_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && op_ff == ptd_pkg::OP_RUN
      |-> n_ff < RCW'(ptd_pkg::MAX_RESULTS))
      else $error("run scan continued past the result limit");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SCAN)
      else $error("accepted request word did not start the sequencer");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_task_dispatcher_core: a scoreboard class
// predicts every reply word; tasks drive requests under random back-pressure.
// Depends on ptd_pkg and the dispatcher RTL only.
module testbench;

   localparam int SLOT_COUNT = ptd_pkg::NUM_SLOTS_DEF;
   localparam logic [ptd_pkg::OP_W-1:0] OP_FIRST_RESERVED = 3'd5;
   localparam logic [ptd_pkg::OP_W-1:0] OP_LAST_RESERVED  = 3'd7;
   localparam int HOLD_CYCLES = 400;

   // One reply word as seen on the rsp_ channel
   typedef struct packed {
      logic [ptd_pkg::OP_W-1:0]   kind;
      logic [ptd_pkg::ID_W-1:0]   slot;
      logic                       ok;
      logic [ptd_pkg::TIME_W-1:0] period;
      logic [ptd_pkg::TIME_W-1:0] last_time;
      logic [ptd_pkg::CNT_W-1:0]  active;
      logic                       last;
   } reply_word_type;

   // Task table mirror and queue of reply words still to come
   class dispatch_scoreboard_type;
      bit                         slot_live [SLOT_COUNT];
      logic [ptd_pkg::TIME_W-1:0] slot_period [SLOT_COUNT];
      logic [ptd_pkg::TIME_W-1:0] slot_last [SLOT_COUNT];
      int                         live_count;
      reply_word_type             pending_replies [$];
      int                         error_count;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_live[i]   = 1'b0;
            slot_period[i] = '0;
            slot_last[i]   = '0;
         end
         slot_live[0]   = 1'b1;
         slot_period[0] = ptd_pkg::DEFAULT_PERIOD;
         live_count     = 1;
         error_count    = 0;
      endfunction

      function void queue_reply(logic [ptd_pkg::OP_W-1:0] kind,
                                logic [ptd_pkg::ID_W-1:0] slot, logic ok,
                                logic [ptd_pkg::TIME_W-1:0] period,
                                logic [ptd_pkg::TIME_W-1:0] last_time,
                                logic last);
         reply_word_type w;
         w.kind      = kind;
         w.slot      = slot;
         w.ok        = ok;
         w.period    = period;
         w.last_time = last_time;
         w.active    = live_count[ptd_pkg::CNT_W-1:0];
         w.last      = last;
         pending_replies.push_back(w);
      endfunction

      // Apply one accepted request word to the table and queue its replies
      function void take_request(logic [ptd_pkg::OP_W-1:0] op,
                                 logic [ptd_pkg::TIME_W-1:0] now,
                                 logic [ptd_pkg::TIME_W-1:0] ivl,
                                 logic [ptd_pkg::ID_W-1:0] id);
         int                         n;
         bit                         done;
         logic [ptd_pkg::TIME_W-1:0] elapsed;
         n    = 0;
         done = 1'b0;
         case (op)
            ptd_pkg::OP_RUN: begin
               for (int i = 0; i < SLOT_COUNT && n < ptd_pkg::MAX_RESULTS; i++) begin
                  elapsed = now - slot_last[i];
                  if (slot_live[i] && elapsed >= slot_period[i]) begin
                     slot_last[i] = now;
                     queue_reply(op, i[ptd_pkg::ID_W-1:0], 1'b1, '0, '0, 1'b0);
                     n++;
                  end
               end
               if (n == 0)
                  queue_reply(op, ptd_pkg::NO_SLOT, 1'b0, '0, '0, 1'b1);
               else
                  pending_replies[pending_replies.size()-1].last = 1'b1;
            end
            ptd_pkg::OP_REGISTER: begin
               // lowest free slot wins
               for (int i = 0; i < SLOT_COUNT && !done; i++) begin
                  if (!slot_live[i]) begin
                     slot_live[i]   = 1'b1;
                     slot_period[i] = ivl;
                     slot_last[i]   = now;
                     live_count++;
                     queue_reply(op, i[ptd_pkg::ID_W-1:0], 1'b1, '0, '0, 1'b1);
                     done = 1'b1;
                  end
               end
               if (!done)
                  queue_reply(op, ptd_pkg::NO_SLOT, 1'b0, '0, '0, 1'b1);
            end
            ptd_pkg::OP_REMOVE: begin
               if (id < SLOT_COUNT && slot_live[id]) begin
                  slot_live[id]   = 1'b0;
                  slot_period[id] = '0;
                  slot_last[id]   = '0;
                  live_count--;
                  queue_reply(op, id, 1'b1, '0, '0, 1'b1);
               end else
                  queue_reply(op, ptd_pkg::NO_SLOT, 1'b0, '0, '0, 1'b1);
            end
            ptd_pkg::OP_OVERWRITE: begin
               // valid bit untouched, even on a removed default task
               slot_period[0] = ivl;
               slot_last[0]   = now;
               queue_reply(op, '0, slot_live[0], '0, '0, 1'b1);
            end
            ptd_pkg::OP_QUERY: begin
               if (id < SLOT_COUNT && slot_live[id])
                  queue_reply(op, id, 1'b1, slot_period[id], slot_last[id], 1'b1);
               else
                  queue_reply(op, ptd_pkg::NO_SLOT, 1'b0, '0, '0, 1'b1);
            end
            default: queue_reply(op, ptd_pkg::NO_SLOT, 1'b0, '0, '0, 1'b1);
         endcase
      endfunction

      function void compare_field(string name, logic [ptd_pkg::TIME_W-1:0] want,
                                  logic [ptd_pkg::TIME_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
         end
      endfunction

      // Check one accepted reply word against the oldest prediction
      function void match_reply(reply_word_type got);
         reply_word_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply word, kind %0d slot %0d", $time, got.kind, got.slot);
            error_count++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("result_kind", want.kind, got.kind);
         compare_field("slot_id", want.slot, got.slot);
         compare_field("ok", want.ok, got.ok);
         compare_field("slot_interval", want.period, got.period);
         compare_field("slot_last_time", want.last_time, got.last_time);
         compare_field("active_count", want.active, got.active);
         compare_field("last", want.last, got.last);
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [ptd_pkg::OP_W-1:0]   req_opcode;
   logic [ptd_pkg::TIME_W-1:0] req_now_ms;
   logic [ptd_pkg::TIME_W-1:0] req_interval_ms;
   logic [ptd_pkg::ID_W-1:0]   req_task_id;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [ptd_pkg::OP_W-1:0]   rsp_result_kind;
   logic [ptd_pkg::ID_W-1:0]   rsp_slot_id;
   logic                       rsp_ok;
   logic [ptd_pkg::TIME_W-1:0] rsp_slot_interval;
   logic [ptd_pkg::TIME_W-1:0] rsp_slot_last_time;
   logic [ptd_pkg::CNT_W-1:0]  rsp_active_count;
   logic                       rsp_last;

   dispatch_scoreboard_type    tally;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         holds_asked;
   int                         holds_granted;
   int                         hold_left;
   logic [ptd_pkg::TIME_W-1:0] ms_clock;

   periodic_task_dispatcher_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_now_ms         (req_now_ms),
      .req_interval_ms    (req_interval_ms),
      .req_task_id        (req_task_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_slot_id        (rsp_slot_id),
      .rsp_ok             (rsp_ok),
      .rsp_slot_interval  (rsp_slot_interval),
      .rsp_slot_last_time (rsp_slot_last_time),
      .rsp_active_count   (rsp_active_count),
      .rsp_last           (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left  = hold_left - 1;
      end else if (holds_asked != holds_granted) begin
         rsp_ready     <= 1'b0;
         hold_left      = HOLD_CYCLES;
         holds_granted  = holds_granted + 1;
      end else
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitors: note accepted requests and check accepted replies
   always @(posedge clock) begin
      reply_word_type got;
      if (!reset && req_valid && req_ready)
         tally.take_request(req_opcode, req_now_ms, req_interval_ms, req_task_id);
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind      = rsp_result_kind;
         got.slot      = rsp_slot_id;
         got.ok        = rsp_ok;
         got.period    = rsp_slot_interval;
         got.last_time = rsp_slot_last_time;
         got.active    = rsp_active_count;
         got.last      = rsp_last;
         tally.match_reply(got);
      end
   end

   // Offer one request word; called and returns at a falling edge
   task automatic send_word(logic [ptd_pkg::OP_W-1:0] op, logic [ptd_pkg::TIME_W-1:0] now,
                            logic [ptd_pkg::TIME_W-1:0] ivl, logic [ptd_pkg::ID_W-1:0] id);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_now_ms      <= now;
      req_interval_ms <= ivl;
      req_task_id     <= id;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly sane traffic on an advancing clock, with some wild values
   task automatic random_request();
      int                         pick;
      logic [ptd_pkg::OP_W-1:0]   op;
      logic [ptd_pkg::TIME_W-1:0] ivl;
      logic [ptd_pkg::ID_W-1:0]   id;
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = ptd_pkg::OP_RUN;
      else if (pick < 58) op = ptd_pkg::OP_REGISTER;
      else if (pick < 78) op = ptd_pkg::OP_REMOVE;
      else if (pick < 92) op = ptd_pkg::OP_QUERY;
      else if (pick < 96) op = ptd_pkg::OP_OVERWRITE;
      else op = ptd_pkg::OP_W'($urandom_range(OP_FIRST_RESERVED, OP_LAST_RESERVED));
      if ($urandom_range(0, 19) == 0)
         ms_clock = $urandom;
      else
         ms_clock = ms_clock + $urandom_range(0, 60);
      pick = $urandom_range(0, 99);
      if (pick < 70)      ivl = $urandom_range(0, 80);
      else if (pick < 85) ivl = '0;
      else                ivl = $urandom;
      if ($urandom_range(0, 9) == 0)
         id = ptd_pkg::ID_W'($urandom_range(0, 255));
      else
         id = ptd_pkg::ID_W'($urandom_range(0, SLOT_COUNT - 1));
      send_word(op, ms_clock, ivl, id);
   endtask

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      tally           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = ptd_pkg::OP_RUN;
      req_now_ms      = '0;
      req_interval_ms = '0;
      req_task_id     = '0;
      rsp_ready       = 1'b0;
      holds_asked     = 0;
      holds_granted   = 0;
      hold_left       = 0;
      ms_clock        = '0;
      send_idle_pct   = 10;
      recv_idle_pct   = 48;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: default task, full table, bad ids, removed default, wrap
      send_word(ptd_pkg::OP_QUERY, '0, '0, '0);
      send_word(ptd_pkg::OP_RUN, '0, '0, '0);
      for (int k = 1; k < SLOT_COUNT; k++)
         send_word(ptd_pkg::OP_REGISTER, '0, '0, '0);
      send_word(ptd_pkg::OP_REGISTER, '0, 32'd5, '0);
      send_word(ptd_pkg::OP_RUN, 32'd100, '0, '0);
      send_word(ptd_pkg::OP_REMOVE, '0, '0, ptd_pkg::NO_SLOT);
      send_word(ptd_pkg::OP_REMOVE, '0, '0, ptd_pkg::ID_W'(SLOT_COUNT));
      send_word(ptd_pkg::OP_QUERY, '0, '0, 8'd200);
      send_word(ptd_pkg::OP_REMOVE, '0, '0, '0);
      send_word(ptd_pkg::OP_OVERWRITE, 32'hFFFF_FFF0, 32'd32, '0);
      send_word(ptd_pkg::OP_QUERY, '0, '0, '0);
      send_word(ptd_pkg::OP_REGISTER, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0);
      send_word(ptd_pkg::OP_OVERWRITE, 32'hFFFF_FFF0, 32'd32, '0);
      send_word(ptd_pkg::OP_RUN, 32'h0000_0010, '0, '0);
      for (int k = OP_FIRST_RESERVED; k <= OP_LAST_RESERVED; k++)
         send_word(ptd_pkg::OP_W'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send_word(ptd_pkg::OP_QUERY, '0, '0, ptd_pkg::ID_W'(SLOT_COUNT - 1));

      // Random traffic in three idling regimes
      ms_clock = 32'h0000_0010;
      for (int k = 0; k < 40; k++)
         random_request();
      send_idle_pct = 48;
      recv_idle_pct = 10;
      for (int k = 0; k < 40; k++)
         random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked   = holds_asked + 1;
      for (int k = 0; k < 40; k++)
         random_request();
      req_valid <= 1'b0;

      // Drain, then allow for any stray words
      while (tally.outstanding() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (tally.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
